FILE: sv/nsd_pkg.sv
// nsd_pkg: shared types, character codes, event and reason codes for the nmea deframer
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package nsd_pkg;

	// framing characters
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;

	// event kinds
	localparam logic [2:0] EV_START     = 3'd0;
	localparam logic [2:0] EV_CHAR      = 3'd1;
	localparam logic [2:0] EV_FIELD_END = 3'd2;
	localparam logic [2:0] EV_GOOD      = 3'd3;
	localparam logic [2:0] EV_ERROR     = 3'd4;
	localparam logic [2:0] EV_DROPPED   = 3'd5;

	// error reasons
	localparam logic [1:0] RSN_MISSING  = 2'd0;
	localparam logic [1:0] RSN_MISMATCH = 2'd1;
	localparam logic [1:0] RSN_NO_CR    = 2'd2;
	localparam logic [1:0] RSN_BAD_HEX  = 2'd3;

	// configuration register indexes
	localparam logic [1:0] CFG_IGNORE_CK  = 2'd0;
	localparam logic [1:0] CFG_MAX_FIELDS = 2'd1;
	localparam logic [1:0] CFG_MAX_LEN    = 2'd2;

	localparam logic [6:0] MAX_FIELDS_RST = 7'd50;
	localparam logic [7:0] MAX_LEN_RST    = 8'd128;

	typedef struct packed {
		logic       ignore_checksum;
		logic [6:0] max_fields;
		logic [7:0] max_field_length;
	} cfg_t;

	typedef struct packed {
		logic [2:0] event_kind;
		logic [7:0] char_out;
		logic [6:0] field_number;
		logic [7:0] char_position;
		logic [1:0] error_reason;
	} event_t;

	// 0..15 for a hex digit, 16 otherwise
	function automatic logic [4:0] hex_value(input logic [7:0] c);
		logic [4:0] v;
		v = 5'd16;
		if (c inside {[8'h30:8'h39]}) begin
			v = {1'b0, c[3:0]};
		end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
			v = {1'b0, c[3:0] + 4'd9};
		end
		return v;
	endfunction

endpackage

FILE: sv/nmea_sentence_deframer.sv
// nmea_sentence_deframer: byte-wise nmea 0183 sentence deframer, at most one event per byte
// latency: an event is on m_tvalid the cycle after its byte transaction when the output
// register is free, later while stalled events wait ahead of it
// throughput: one byte per cycle while m_tready keeps up; s_tready comes from a register and
// drops only while two events wait (output register and skid entry both full)
// reset: arst_n clears sentence state and buffered events, limits 50 fields / 128 characters
`timescale 1ns / 1ps

module nmea_sentence_deframer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tlast,   // chunk_last
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [7:0] char_out, [14:8] field_number,
	                               // [22:15] char_position, [24:23] error_reason, zero above
	output logic [2:0]  m_tuser,   // [2:0] event_kind
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);
	import nsd_pkg::*;

	cfg_t   cfg;
	event_t res, out_ev;
	logic   res_valid, step, space;
	logic   chunk_last;

	// state persists across chunks, so the chunk mark carries no meaning here
	assign chunk_last = s_tlast;

	assign s_tready = space;
	assign step     = s_tvalid && s_tready;

	nsd_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	nsd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.step      (step),
		.data_byte (s_tdata),
		.res_valid (res_valid),
		.res       (res)
	);

	nsd_out_buf u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (step && res_valid),
		.push_data (res),
		.space     (space),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (out_ev)
	);

	assign m_tuser = out_ev.event_kind;
	assign m_tdata = {7'd0, out_ev.error_reason, out_ev.char_position,
		out_ev.field_number, out_ev.char_out};

`ifndef SYNTHESIS
	a_chunk_no_effect: assert property (@(posedge clk) disable iff (!arst_n)
		(step && chunk_last && s_tdata == CH_DOLLAR) |-> res_valid)
		else $error("start byte produced no event");
`endif

endmodule

FILE: sv/nsd_cfg_regs.sv
// nsd_cfg_regs: configuration registers of the nmea deframer
// depends on nsd_pkg for register indexes and reset values
`timescale 1ns / 1ps

module nsd_cfg_regs (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [1:0]    cfg_index,
	input  logic [7:0]    cfg_data,
	output nsd_pkg::cfg_t cfg
);
	import nsd_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ignore_checksum  <= 1'b0;
			cfg_q.max_fields       <= MAX_FIELDS_RST;
			cfg_q.max_field_length <= MAX_LEN_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_IGNORE_CK:  cfg_q.ignore_checksum  <= cfg_data[0];
				CFG_MAX_FIELDS: cfg_q.max_fields       <= cfg_data[6:0];
				CFG_MAX_LEN:    cfg_q.max_field_length <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

FILE: sv/nsd_parser.sv
// nsd_parser: sentence state registers and the per-byte decode that yields at most one event
// depends on nsd_pkg for character codes, event codes and the hex decoder
`timescale 1ns / 1ps

module nsd_parser (
	input  logic            clk,
	input  logic            arst_n,
	input  nsd_pkg::cfg_t   cfg,
	input  logic            step,
	input  logic [7:0]      data_byte,
	output logic            res_valid,
	output nsd_pkg::event_t res
);
	import nsd_pkg::*;

	logic       in_sentence_q, in_ck_q, seen_cr_q;
	logic [7:0] xor_q;
	logic [6:0] fields_q;
	logic [7:0] chars_q;
	logic [1:0] digits_q;
	logic [3:0] high_q;

	logic       n_in_sentence, n_in_ck, n_seen_cr;
	logic [7:0] n_xor;
	logic [6:0] n_fields;
	logic [7:0] n_chars;
	logic [1:0] n_digits;
	logic [3:0] n_high;
	logic       clr, set_in;
	logic [4:0] hv;
	logic [7:0] fields_inc;
	logic [8:0] chars_inc;
	logic       field_over;

	assign hv         = hex_value(data_byte);
	assign fields_inc = {1'b0, fields_q} + 8'd1;
	assign chars_inc  = {1'b0, chars_q} + 9'd1;
	assign field_over = fields_inc > {1'b0, cfg.max_fields};

	always_comb begin
		n_in_sentence = in_sentence_q;
		n_in_ck       = in_ck_q;
		n_seen_cr     = seen_cr_q;
		n_xor         = xor_q;
		n_fields      = fields_q;
		n_chars       = chars_q;
		n_digits      = digits_q;
		n_high        = high_q;
		clr           = 1'b0;
		set_in        = 1'b0;
		res_valid     = 1'b0;
		res           = '0;
		res.field_number = fields_q;

		if (data_byte == CH_DOLLAR) begin
			clr              = 1'b1;
			set_in           = 1'b1;
			res_valid        = 1'b1;
			res.event_kind   = EV_START;
			res.field_number = '0;
		end else if (in_sentence_q) begin
			if (data_byte == CH_CR) begin
				n_seen_cr = 1'b1;
			end else if (data_byte == CH_LF) begin
				res_valid = 1'b1;
				clr       = 1'b1;
				if (!seen_cr_q) begin
					res.event_kind   = EV_ERROR;
					res.error_reason = RSN_NO_CR;
				end else if (!in_ck_q || digits_q != 2'd2) begin
					res.event_kind   = EV_ERROR;
					res.error_reason = RSN_MISSING;
				end else begin
					res.event_kind = EV_GOOD;
				end
			end else if (in_ck_q) begin
				// bytes after both digits are ignored up to lf
				if (digits_q != 2'd2) begin
					if (hv[4]) begin
						res_valid        = 1'b1;
						clr              = 1'b1;
						res.event_kind   = EV_ERROR;
						res.error_reason = RSN_BAD_HEX;
					end else if (digits_q == 2'd0) begin
						n_high   = hv[3:0];
						n_digits = 2'd1;
					end else begin
						n_digits = 2'd2;
						if (!cfg.ignore_checksum && {high_q, hv[3:0]} != xor_q) begin
							res_valid        = 1'b1;
							clr              = 1'b1;
							res.event_kind   = EV_ERROR;
							res.error_reason = RSN_MISMATCH;
						end
					end
				end
			end else begin
				if (data_byte != CH_STAR) begin
					n_xor = xor_q ^ data_byte;
				end
				res_valid = 1'b1;
				if (data_byte == CH_STAR || data_byte == CH_COMMA) begin
					// field close, dropped when it would exceed the field limit
					res.char_position = chars_q;
					if (field_over) begin
						res.event_kind = EV_DROPPED;
						clr            = 1'b1;
					end else begin
						res.event_kind = EV_FIELD_END;
						n_fields       = fields_inc[6:0];
						n_chars        = '0;
						if (data_byte == CH_STAR) begin
							n_in_ck  = 1'b1;
							n_digits = '0;
							n_high   = '0;
						end
					end
				end else if (chars_inc > {1'b0, cfg.max_field_length}) begin
					res.event_kind    = EV_DROPPED;
					res.char_position = chars_q;
					clr               = 1'b1;
				end else begin
					res.event_kind    = EV_CHAR;
					res.char_out      = data_byte;
					res.char_position = chars_q;
					n_chars           = chars_inc[7:0];
				end
			end
		end

		if (clr) begin
			n_in_sentence = set_in;
			n_in_ck       = 1'b0;
			n_seen_cr     = 1'b0;
			n_xor         = '0;
			n_fields      = '0;
			n_chars       = '0;
			n_digits      = '0;
			n_high        = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_sentence_q <= 1'b0;
			in_ck_q       <= 1'b0;
			seen_cr_q     <= 1'b0;
			xor_q         <= '0;
			fields_q      <= '0;
			chars_q       <= '0;
			digits_q      <= '0;
			high_q        <= '0;
		end else if (step) begin
			in_sentence_q <= n_in_sentence;
			in_ck_q       <= n_in_ck;
			seen_cr_q     <= n_seen_cr;
			xor_q         <= n_xor;
			fields_q      <= n_fields;
			chars_q       <= n_chars;
			digits_q      <= n_digits;
			high_q        <= n_high;
		end
	end

`ifndef SYNTHESIS
	a_ck_in_sentence: assert property (@(posedge clk) disable iff (!arst_n)
		in_ck_q |-> in_sentence_q)
		else $error("checksum digit state outside a sentence");

	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!in_sentence_q |-> (fields_q == '0 && chars_q == '0 && xor_q == '0
			&& !seen_cr_q && digits_q == '0))
		else $error("sentence state not cleared while idle");

	a_digits_range: assert property (@(posedge clk) disable iff (!arst_n)
		digits_q != 2'd3)
		else $error("checksum digit count out of range");

	a_start_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		(step && data_byte == CH_DOLLAR) |=> (in_sentence_q && fields_q == '0))
		else $error("start byte did not open a fresh sentence");
`endif

endmodule

FILE: sv/nsd_out_buf.sv
// nsd_out_buf: output register with a skid entry so s_tready never depends combinationally on m_tready
// depends on nsd_pkg for the event type
`timescale 1ns / 1ps

module nsd_out_buf (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  nsd_pkg::event_t push_data,
	output logic            space,
	output logic            out_valid,
	input  logic            out_ready,
	output nsd_pkg::event_t out_data
);
	import nsd_pkg::*;

	logic   out_valid_q, skid_valid_q;
	event_t out_q, skid_q;
	logic   pop;

	assign pop       = out_valid_q && out_ready;
	assign space     = !skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				skid_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (!out_valid_q || pop) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				out_q <= skid_q;
			end
		end else if (push) begin
			if (!out_valid_q || pop) begin
				out_q <= push_data;
			end else begin
				skid_q <= push_data;
			end
		end
	end

`ifndef SYNTHESIS
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry held with empty output register");

	a_skid_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_valid_q && pop) |=> (out_valid_q && !skid_valid_q))
		else $error("skid entry lost on drain");
`endif

endmodule
